// ===== rtl/core/marp_pkg.sv =====
// ----------------------------------------------------------------------------
// marp_pkg
// Shared constants for the arpeggiator step block: codes, register indexes,
// reset values and default sizes.
// ----------------------------------------------------------------------------
package marp_pkg;

    localparam int NOTE_RANGE         = 128;
    localparam int LIST_DEPTH_DEFAULT = 1024;
    localparam int PHASE_BITS_DEFAULT = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Input actions
    localparam logic [1:0] ACT_NOTE_ON  = 2'd0;
    localparam logic [1:0] ACT_NOTE_OFF = 2'd1;
    localparam logic [1:0] ACT_BLOCK    = 2'd2;

    // Event kinds
    localparam logic EV_OFF = 1'b0;
    localparam logic EV_ON  = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_UP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ASCENDING     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_STEPS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_MODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THIRDS_MODE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_DURATION = 3'd6;

    // Reset values
    localparam logic [3:0]  RST_OCTAVE_COUNT  = 4'd1;
    localparam logic        RST_OCTAVE_UP     = 1'b1;
    localparam logic        RST_ASCENDING     = 1'b1;
    localparam logic [2:0]  RST_SCALE_STEPS   = 3'd0;
    localparam logic        RST_SKIP_MODE     = 1'b0;
    localparam logic        RST_THIRDS_MODE   = 1'b0;
    localparam logic [15:0] RST_NOTE_DURATION = 16'd7200;

    localparam logic [6:0] NOTE_MAX   = 7'd127;
    localparam logic [3:0] OCT_STEP   = 4'd12;
    localparam logic [11:0] OFF_MAX   = 12'd4095;

endpackage

// ===== rtl/core/marp_ifs.sv =====
// ----------------------------------------------------------------------------
// marp_in_if / marp_out_if
// Valid/ready channels carrying input items and result events.
// ----------------------------------------------------------------------------
interface marp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [6:0]  note;
    logic [12:0] block_samples;

    modport source (output valid, action, note, block_samples, input ready);
    modport sink   (input valid, action, note, block_samples, output ready);
endinterface

interface marp_out_if;
    logic        valid;
    logic        ready;
    logic        event_kind;
    logic [6:0]  out_note;
    logic [11:0] sample_offset;
    logic        last_of_run;

    modport source (output valid, event_kind, out_note, sample_offset, last_of_run,
                    input ready);
    modport sink   (input valid, event_kind, out_note, sample_offset, last_of_run,
                    output ready);
endinterface

// ===== rtl/core/midi_arpeggiator_step_top.sv =====
// ----------------------------------------------------------------------------
// midi_arpeggiator_step_top
// Arpeggiator step: held-note set, play list build and step sequencing.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries note-on, note-off and end-of-audio-block transactions.
//   o_out carries up to two events per block end: a note-off for the
//   sounding note, then a note-on for the next list entry; last_of_run
//   marks the final one. The register port writes one setting per cycle
//   and must be used only while the block is idle; the block does not enforce this.
// Timing:
//   One item is handled at a time; i_in.ready is high only when idle.
//   Note-on/off walks the octave copies.
//   A block end runs the shared remainder unit (one quotient bit per cycle)
//   for the phase; when a step fires it then scans the 128 held-note flags,
//   writing at most one play-list entry per cycle (held notes and their
//   scale notes), and if the list is not empty runs the remainder unit
//   again for the step index and reads the list RAM. With skip and thirds
//   modes both set the scan does not run and the list length is zero.
//   Events leave through an output register, so a stall on o_out only
//   holds the sequencer when an event is due while that register is full.
// Reset: clears held notes, step index, phase, the sounding note and the
//   registers to their defaults. The play list RAM is not cleared; it is
//   always rebuilt before it is read.
// ----------------------------------------------------------------------------
module midi_arpeggiator_step_top #(
    parameter int LIST_DEPTH = marp_pkg::LIST_DEPTH_DEFAULT,
    parameter int PHASE_BITS = marp_pkg::PHASE_BITS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    marp_in_if.sink                         i_in,
    marp_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [marp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [marp_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int A_W   = $clog2(LIST_DEPTH);
    localparam int N_W   = $clog2(LIST_DEPTH + 1);
    localparam int SI_W  = $clog2(2 * LIST_DEPTH);
    localparam int T_W   = ((PHASE_BITS > 13) ? PHASE_BITS : 13) + 1;
    localparam int D_W0  = (T_W > 16) ? T_W : 16;
    localparam int D_W   = (D_W0 > SI_W + 1) ? D_W0 : SI_W + 1;
    localparam int C_W   = $clog2(D_W + 1);

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_OCT    = 4'd1;
    localparam logic [3:0] S_PDIV   = 4'd2;
    localparam logic [3:0] S_BSCAN  = 4'd3;
    localparam logic [3:0] S_BSCALE = 4'd4;
    localparam logic [3:0] S_LEN    = 4'd5;
    localparam logic [3:0] S_EOFF   = 4'd6;
    localparam logic [3:0] S_IDIV   = 4'd7;
    localparam logic [3:0] S_MAP    = 4'd8;
    localparam logic [3:0] S_RD     = 4'd9;
    localparam logic [3:0] S_EON    = 4'd10;

    // Configuration
    logic [3:0]  r_oct_cnt;
    logic        r_oct_up;
    logic        r_asc;
    logic [2:0]  r_scale;
    logic        r_skip;
    logic        r_thirds;
    logic [15:0] r_dur;

    // State
    logic [3:0]              r_state;
    logic [127:0]            r_held;
    logic [SI_W-1:0]         r_si;
    logic [6:0]              r_snd;
    logic                    r_snd_v;
    logic [PHASE_BITS-1:0]   r_phase;

    // Item working registers
    logic                    r_act_on;
    logic [3:0]              r_i;
    logic signed [9:0]       r_cur;
    logic                    r_fire;
    logic [11:0]             r_off;
    logic                    r_major;
    logic                    r_use_thirds;
    logic                    r_use_skip;
    logic [7:0]              r_v;
    logic [7:0]              r_t;
    logic [2:0]              r_j;
    logic [N_W-1:0]          r_n;
    logic [SI_W-1:0]         r_len;
    logic [A_W-1:0]          r_addr;
    logic [6:0]              r_rd;

    // Shared remainder unit
    logic [D_W-1:0]          r_dq;
    logic [D_W-1:0]          r_dd;
    logic [D_W-1:0]          r_rem;
    logic [C_W-1:0]          r_dcnt;

    // Output register
    logic                    r_out_v;
    logic                    r_o_kind;
    logic [6:0]              r_o_note;
    logic [11:0]             r_o_off;
    logic                    r_o_last;

    logic [6:0] mem [LIST_DEPTH];

    // ---------------- combinational helpers ----------------
    logic                    in_acc;
    logic                    slot_free;
    logic                    out_load;
    logic [15:0]             dur_eff;
    logic [D_W-1:0]          ph_d;
    logic [D_W-1:0]          du_d;
    logic [D_W-1:0]          total;
    logic                    fire;
    logic [D_W-1:0]          d_diff;
    logic [D_W-1:0]          lim;
    logic [11:0]             off;
    logic [D_W:0]            div_tmp;
    logic [D_W:0]            div_sub;
    logic [D_W-1:0]          div_rem;
    logic                    div_last;
    logic [3:0]              deg;
    logic [7:0]              t_next;
    logic                    mem_we;
    logic [A_W-1:0]          mem_waddr;
    logic [6:0]              mem_wdata;
    logic [SI_W:0]           k_ext;
    logic [SI_W:0]           m_half;
    logic [SI_W:0]           map_idx;
    logic [D_W-1:0]          idx_dividend;
    logic [SI_W:0]           n_ext;

    assign in_acc    = i_in.valid && (r_state == S_IDLE);
    assign slot_free = !r_out_v || o_out.ready;
    // Load the output register with a note-off or a note-on this cycle.
    assign out_load  = ((r_state == S_EOFF) && r_snd_v && slot_free) ||
                       ((r_state == S_EON) && slot_free);
    assign dur_eff   = (r_dur == 16'd0) ? 16'd1 : r_dur;
    assign ph_d      = D_W'(r_phase);
    assign du_d      = D_W'(dur_eff);
    assign total     = ph_d + D_W'(i_in.block_samples);
    assign fire      = total >= du_d;
    assign d_diff    = du_d - ph_d;
    assign lim       = D_W'(i_in.block_samples) - D_W'(1);

    always_comb begin
        if (ph_d >= du_d || i_in.block_samples == 13'd0) begin
            off = 12'd0;
        end else if (d_diff <= lim) begin
            off = (d_diff > D_W'(marp_pkg::OFF_MAX)) ? marp_pkg::OFF_MAX : d_diff[11:0];
        end else begin
            off = (lim > D_W'(marp_pkg::OFF_MAX)) ? marp_pkg::OFF_MAX : lim[11:0];
        end
    end

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign div_tmp  = {r_rem, r_dq[D_W-1]};
    assign div_sub  = div_tmp - {1'b0, r_dd};
    assign div_rem  = (div_tmp >= {1'b0, r_dd}) ? div_sub[D_W-1:0] : div_tmp[D_W-1:0];
    assign div_last = (r_dcnt == C_W'(D_W - 1));

    // Major-scale interval: half step up from the third and seventh degrees.
    assign deg    = {1'b0, r_j} + 4'd1;
    assign t_next = r_t + (((deg == 4'd3) || (deg == 4'd7)) ? 8'd1 : 8'd2);

    assign n_ext = (SI_W+1)'(r_n);
    assign idx_dividend = r_asc ? D_W'(r_si) + D_W'(1)
                                : D_W'(r_si) + D_W'(r_len) - D_W'(1);

    always_comb begin
        k_ext  = (SI_W+1)'(r_si);
        m_half = (n_ext + (SI_W+1)'(1)) >> 1;
        if (r_use_thirds) begin
            map_idx = k_ext[0] ? ((k_ext + (SI_W+1)'(3)) >> 1) : (k_ext >> 1);
        end else if (r_use_skip) begin
            map_idx = (k_ext < m_half) ? (k_ext << 1)
                                       : (((k_ext - m_half) << 1) + (SI_W+1)'(1));
        end else begin
            map_idx = k_ext;
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_n[A_W-1:0];
        mem_wdata = r_v[6:0];
        if (r_n < N_W'(LIST_DEPTH)) begin
            if (r_state == S_BSCAN && !r_v[7] && r_held[r_v[6:0]]) begin
                mem_we = 1'b1;
            end else if (r_state == S_BSCALE && t_next <= 8'd127) begin
                mem_we    = 1'b1;
                mem_wdata = t_next[6:0];
            end
        end
    end

    // ---------------- play list RAM ----------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= mem[r_addr];
    end

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct_cnt <= marp_pkg::RST_OCTAVE_COUNT;
            r_oct_up  <= marp_pkg::RST_OCTAVE_UP;
            r_asc     <= marp_pkg::RST_ASCENDING;
            r_scale   <= marp_pkg::RST_SCALE_STEPS;
            r_skip    <= marp_pkg::RST_SKIP_MODE;
            r_thirds  <= marp_pkg::RST_THIRDS_MODE;
            r_dur     <= marp_pkg::RST_NOTE_DURATION;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                marp_pkg::REG_OCTAVE_COUNT:  r_oct_cnt <= i_cfg_data[3:0];
                marp_pkg::REG_OCTAVE_UP:     r_oct_up  <= i_cfg_data[0];
                marp_pkg::REG_ASCENDING:     r_asc     <= i_cfg_data[0];
                marp_pkg::REG_SCALE_STEPS:   r_scale   <= i_cfg_data[2:0];
                marp_pkg::REG_SKIP_MODE:     r_skip    <= i_cfg_data[0];
                marp_pkg::REG_THIRDS_MODE:   r_thirds  <= i_cfg_data[0];
                marp_pkg::REG_NOTE_DURATION: r_dur     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_held  <= '0;
            r_si    <= '0;
            r_snd_v <= 1'b0;
            r_phase <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.action == marp_pkg::ACT_NOTE_ON ||
                            i_in.action == marp_pkg::ACT_NOTE_OFF) begin
                            r_act_on <= (i_in.action == marp_pkg::ACT_NOTE_ON);
                            r_i      <= 4'd0;
                            r_cur    <= 10'(i_in.note);
                            r_state  <= S_OCT;
                        end else if (i_in.action == marp_pkg::ACT_BLOCK) begin
                            r_fire  <= fire;
                            r_off   <= off;
                            r_dq    <= total;
                            r_dd    <= du_d;
                            r_rem   <= '0;
                            r_dcnt  <= '0;
                            r_state <= S_PDIV;
                        end
                    end
                end
                S_OCT: begin
                    // Walk the octave copies one per cycle.
                    if (r_i == r_oct_cnt) begin
                        r_state <= S_IDLE;
                    end else begin
                        if (r_cur >= 10'sd0 && r_cur <= 10'sd127) begin
                            r_held[r_cur[6:0]] <= r_act_on;
                        end
                        r_cur <= r_oct_up ? r_cur + 10'sd12 : r_cur - 10'sd12;
                        r_i   <= r_i + 4'd1;
                    end
                end
                S_PDIV: begin
                    r_rem  <= div_rem;
                    r_dq   <= r_dq << 1;
                    r_dcnt <= r_dcnt + C_W'(1);
                    if (div_last) begin
                        r_phase      <= div_rem[PHASE_BITS-1:0];
                        r_major      <= r_thirds ? (r_scale > 3'd1) : (r_scale != 3'd0);
                        r_use_thirds <= r_thirds && !r_skip && (r_scale > 3'd1);
                        r_use_skip   <= r_skip && !r_thirds;
                        r_v          <= 8'd0;
                        r_n          <= '0;
                        if (!r_fire) begin
                            r_state <= S_IDLE;
                        end else if (r_skip && r_thirds) begin
                            r_len   <= '0;
                            r_state <= S_EOFF;
                        end else begin
                            r_state <= S_BSCAN;
                        end
                    end
                end
                S_BSCAN: begin
                    if (r_v[7]) begin
                        r_state <= S_LEN;
                    end else if (r_held[r_v[6:0]]) begin
                        if (r_n < N_W'(LIST_DEPTH)) begin
                            r_n <= r_n + N_W'(1);
                        end
                        if (r_major && r_scale != 3'd0) begin
                            r_t     <= r_v;
                            r_j     <= 3'd0;
                            r_state <= S_BSCALE;
                        end else begin
                            r_v <= r_v + 8'd1;
                        end
                    end else begin
                        r_v <= r_v + 8'd1;
                    end
                end
                S_BSCALE: begin
                    // Drop scale notes that run past the top note.
                    if (t_next > 8'd127) begin
                        r_v     <= r_v + 8'd1;
                        r_state <= S_BSCAN;
                    end else begin
                        if (r_n < N_W'(LIST_DEPTH)) begin
                            r_n <= r_n + N_W'(1);
                        end
                        r_t <= t_next;
                        r_j <= r_j + 3'd1;
                        if (r_j + 3'd1 == r_scale || r_j == 3'd7) begin
                            r_v     <= r_v + 8'd1;
                            r_state <= S_BSCAN;
                        end
                    end
                end
                S_LEN: begin
                    if (r_use_thirds) begin
                        if (r_n == '0) begin
                            r_len <= '0;
                        end else if (r_n <= N_W'(2)) begin
                            r_len <= SI_W'(1);
                        end else begin
                            r_len <= SI_W'(n_ext + n_ext - (SI_W+1)'(3));
                        end
                    end else begin
                        r_len <= SI_W'(r_n);
                    end
                    r_state <= S_EOFF;
                end
                S_EOFF: begin
                    if (!r_snd_v) begin
                        r_state <= (r_len == '0) ? S_IDLE : S_IDIV;
                    end else if (slot_free) begin
                        r_o_kind <= marp_pkg::EV_OFF;
                        r_o_note <= r_snd;
                        r_o_off  <= r_off;
                        r_o_last <= (r_len == '0);
                        r_snd_v  <= 1'b0;
                        r_state  <= (r_len == '0) ? S_IDLE : S_IDIV;
                    end
                    r_dq   <= idx_dividend;
                    r_dd   <= D_W'(r_len);
                    r_rem  <= '0;
                    r_dcnt <= '0;
                end
                S_IDIV: begin
                    r_rem  <= div_rem;
                    r_dq   <= r_dq << 1;
                    r_dcnt <= r_dcnt + C_W'(1);
                    if (div_last) begin
                        r_si    <= div_rem[SI_W-1:0];
                        r_state <= S_MAP;
                    end
                end
                S_MAP: begin
                    r_addr  <= map_idx[A_W-1:0];
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_EON;
                end
                S_EON: begin
                    if (slot_free) begin
                        r_o_kind <= marp_pkg::EV_ON;
                        r_o_note <= r_rd;
                        r_o_off  <= r_off;
                        r_o_last <= 1'b1;
                        r_snd    <= r_rd;
                        r_snd_v  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_v;
    assign o_out.event_kind    = r_o_kind;
    assign o_out.out_note      = r_o_note;
    assign o_out.sample_offset = r_o_off;
    assign o_out.last_of_run   = r_o_last;

endmodule

// ===== rtl/core/marp_chk.sv =====
// ----------------------------------------------------------------------------
// marp_chk
// Port-level checks for the arpeggiator step block, bound to the top level.
// ----------------------------------------------------------------------------
module marp_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_action,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_kind,
    input logic [6:0] i_out_note,
    input logic       i_out_last
);

    // A stalled event holds its note, kind and last flag.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_note)
            && $stable(i_out_kind) && $stable(i_out_last))
        else $error("stalled event changed");

    // A note-on always closes the run.
    a_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == marp_pkg::EV_ON) |-> i_out_last)
        else $error("note-on not last of run");

    // Any real action keeps the block busy on the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_action == marp_pkg::ACT_NOTE_ON ||
            i_in_action == marp_pkg::ACT_NOTE_OFF ||
            i_in_action == marp_pkg::ACT_BLOCK) |=> !i_in_ready)
        else $error("ready right after accepted action");

endmodule

bind midi_arpeggiator_step_top marp_chk u_marp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_action (i_in.action),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.event_kind),
    .i_out_note  (o_out.out_note),
    .i_out_last  (o_out.last_of_run)
);
